@@ rtl/core/gmb_pkg.sv @@
// gmb_pkg: shared types and constants of the gray mirror box blur.
// No dependencies; used by every file of the block but gmb_stream_if.
package gmb_pkg;

  localparam int CFG_W    = 11;
  localparam int COL_W    = 11;
  localparam int ROW_W    = 12;
  localparam int WINDOW   = 9;
  localparam int HALF     = WINDOW / 2;
  localparam int DELAY    = WINDOW - HALF;
  localparam int SLOTS    = WINDOW + 1;
  localparam int SLOT_W   = 4;
  localparam int CSUM_W   = 12;
  localparam int TOT_W    = 15;
  localparam int PROD_W   = 29;
  localparam int DIV_SH   = 20;
  localparam int DIV10_SH = 16;

  localparam logic [7:0]  GRAY_R    = 8'd54;
  localparam logic [7:0]  GRAY_G    = 8'd184;
  localparam logic [7:0]  GRAY_B    = 8'd18;
  localparam logic [13:0] DIV_MUL   = 14'd12946;
  localparam logic [12:0] DIV10_MUL = 13'd6554;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic ACT_PIXEL = 1'b0;

  typedef struct packed {
    logic       action;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_item_t;

  typedef struct packed {
    logic [7:0] gray_out;
    logic       end_of_row;
    logic       end_of_frame;
  } out_item_t;

  typedef struct packed {
    logic [7:0]       gray;
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0] wr_col;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] orow;
    logic             emit;
    logic             row_start;
    logic             last_col;
    logic             eof;
  } cmd_t;

endpackage

@@ rtl/core/gmb_stream_if.sv @@
// gmb_stream_if: valid/ready channel carrying one payload per transaction.
// Payload type is a parameter; types come from gmb_pkg.
interface gmb_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ rtl/core/gmb_front.sv @@
// gmb_front: accepts input transactions, converts to gray, tracks row/column
// and issues store/emit commands. Depends on gmb_pkg.
module gmb_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [gmb_pkg::CFG_W-1:0]     w_eff,
  input  logic [gmb_pkg::CFG_W-1:0]     h_eff,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gmb_pkg::in_item_t             in_data,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output gmb_pkg::cmd_t                 cmd
);

  logic [gmb_pkg::COL_W-1:0]  col_r, col_nxt, col;
  logic [gmb_pkg::ROW_W-1:0]  row_r, row_nxt, row, hlim, rq, rem;
  logic [gmb_pkg::ROW_W+12:0] qprod;
  logic [15:0]                gsum;
  logic                       last_col, last_row, fire;

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign fire      = in_valid && cmd_ready;

  always_comb begin
    hlim = gmb_pkg::ROW_W'(h_eff) + gmb_pkg::ROW_W'(gmb_pkg::DELAY - 1);
    col  = (col_r >= w_eff) ? (w_eff - 1'b1) : col_r;
    row  = (row_r > hlim) ? hlim : row_r;
    // row mod 10 by reciprocal multiply
    qprod = (gmb_pkg::ROW_W + 13)'(row) * (gmb_pkg::ROW_W + 13)'(gmb_pkg::DIV10_MUL);
    rq    = gmb_pkg::ROW_W'(qprod >> gmb_pkg::DIV10_SH);
    rem   = row - ((rq << 3) + (rq << 1));
    gsum = 16'(gmb_pkg::GRAY_R) * 16'(in_data.red)
         + 16'(gmb_pkg::GRAY_G) * 16'(in_data.green)
         + 16'(gmb_pkg::GRAY_B) * 16'(in_data.blue);
    last_col = (col == w_eff - 1'b1);
    last_row = (row == hlim);

    cmd.gray      = (in_data.action == gmb_pkg::ACT_PIXEL) ? gsum[15:8] : 8'd0;
    cmd.slot      = rem[gmb_pkg::SLOT_W-1:0];
    cmd.wr_col    = w_eff - 1'b1 - col;
    cmd.col       = col;
    cmd.orow      = row - gmb_pkg::ROW_W'(gmb_pkg::DELAY);
    cmd.emit      = (row >= gmb_pkg::ROW_W'(gmb_pkg::DELAY));
    cmd.row_start = (col == '0);
    cmd.last_col  = last_col;
    cmd.eof       = last_col && last_row;

    col_nxt = col_r;
    row_nxt = row_r;
    if (fire) begin
      if (last_col) begin
        col_nxt = '0;
        if (last_row) begin
          row_nxt = '0;
        end else begin
          row_nxt = row + 1'b1;
        end
      end else begin
        col_nxt = col + 1'b1;
        row_nxt = row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

@@ rtl/core/gmb_queue.sv @@
// gmb_queue: two-entry command queue between front and back.
// Depends on gmb_pkg.
module gmb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  gmb_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output gmb_pkg::cmd_t pop_data
);

  gmb_pkg::cmd_t ent_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = ent_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ rtl/core/gmb_back.sv @@
// gmb_back: line store, column sums, sliding window total, divide by 81
// and output register. Depends on gmb_pkg.
module gmb_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [gmb_pkg::CFG_W-1:0] w_eff,
  input  logic [gmb_pkg::CFG_W-1:0] h_eff,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  gmb_pkg::cmd_t             cmd,
  output logic                      out_valid,
  input  logic                      out_ready,
  output gmb_pkg::out_item_t        out_data
);

  localparam int DEPTH  = gmb_pkg::SLOTS * MAX_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int XS_W   = gmb_pkg::COL_W + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SUM  = 5'b00010,
    S_PUSH = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  logic [7:0]                  mem [DEPTH];
  state_t                      st_r;
  gmb_pkg::cmd_t               c_r;
  logic [XS_W-1:0]             xs_r, xend_r;
  logic [3:0]                  k_r;
  logic [gmb_pkg::SLOT_W-1:0]  sk_r, sk_first;
  logic [gmb_pkg::CSUM_W-1:0]  acc_r;
  logic [gmb_pkg::CSUM_W-1:0]  win_r [gmb_pkg::WINDOW];
  logic [gmb_pkg::TOT_W-1:0]   tot_r;
  logic [gmb_pkg::PROD_W-1:0]  prod_r;
  logic [7:0]                  rd_data_r;
  logic                        rd_ok_r;
  logic                        issue, row_ok, x_ok, pop;
  logic [gmb_pkg::ROW_W:0]     ysum;
  logic [ADDR_W-1:0]           rd_addr, wr_addr;
  logic                        out_valid_r;
  gmb_pkg::out_item_t          out_r;

  assign cmd_ready = (st_r == S_IDLE);
  assign pop       = cmd_valid && cmd_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sk_first = (cmd.slot == gmb_pkg::SLOT_W'(gmb_pkg::SLOTS - 1)) ? '0 : cmd.slot + 1'b1;
    issue    = (st_r == S_SUM) && (k_r < 4'(gmb_pkg::WINDOW));
    ysum     = {1'b0, c_r.orow} + (gmb_pkg::ROW_W + 1)'(k_r);
    row_ok   = (ysum >= (gmb_pkg::ROW_W + 1)'(gmb_pkg::HALF))
            && ((ysum - (gmb_pkg::ROW_W + 1)'(gmb_pkg::HALF)) < (gmb_pkg::ROW_W + 1)'(h_eff));
    x_ok     = (xs_r < XS_W'(w_eff));
    rd_addr  = ADDR_W'(32'(sk_r) * MAX_WIDTH) + ADDR_W'(xs_r[gmb_pkg::COL_W-1:0]);
    wr_addr  = ADDR_W'(32'(cmd.slot) * MAX_WIDTH) + ADDR_W'(cmd.wr_col);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mem[wr_addr] <= cmd.gray;
    end
    if (issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_ok_r     <= 1'b0;
      k_r         <= '0;
    end else begin
      rd_ok_r <= issue && row_ok && x_ok;
      if (out_valid_r && out_ready && st_r != S_OUT) out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (pop) begin
            c_r <= cmd;
            if (cmd.emit) begin
              k_r   <= '0;
              sk_r  <= sk_first;
              acc_r <= '0;
              st_r  <= S_SUM;
              if (cmd.row_start) begin
                for (int i = 0; i < gmb_pkg::WINDOW; i++) win_r[i] <= '0;
                tot_r  <= '0;
                xs_r   <= '0;
                xend_r <= XS_W'(gmb_pkg::HALF);
              end else begin
                xs_r   <= XS_W'(cmd.col) + XS_W'(gmb_pkg::HALF);
                xend_r <= XS_W'(cmd.col) + XS_W'(gmb_pkg::HALF);
              end
            end
          end
        end
        S_SUM: begin
          if (rd_ok_r) acc_r <= acc_r + gmb_pkg::CSUM_W'(rd_data_r);
          if (issue) begin
            k_r  <= k_r + 1'b1;
            sk_r <= (sk_r == gmb_pkg::SLOT_W'(gmb_pkg::SLOTS - 1)) ? '0 : sk_r + 1'b1;
          end else begin
            st_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          for (int i = 0; i < gmb_pkg::WINDOW - 1; i++) win_r[i] <= win_r[i + 1];
          win_r[gmb_pkg::WINDOW - 1] <= acc_r;
          tot_r <= tot_r + gmb_pkg::TOT_W'(acc_r) - gmb_pkg::TOT_W'(win_r[0]);
          if (xs_r == xend_r) begin
            st_r <= S_DIV;
          end else begin
            xs_r  <= xs_r + 1'b1;
            k_r   <= '0;
            sk_r  <= (c_r.slot == gmb_pkg::SLOT_W'(gmb_pkg::SLOTS - 1)) ? '0 : c_r.slot + 1'b1;
            acc_r <= '0;
            st_r  <= S_SUM;
          end
        end
        S_DIV: begin
          prod_r <= gmb_pkg::PROD_W'(tot_r) * gmb_pkg::PROD_W'(gmb_pkg::DIV_MUL);
          st_r   <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_r.gray_out     <= prod_r[gmb_pkg::DIV_SH +: 8];
            out_r.end_of_row   <= c_r.last_col;
            out_r.end_of_frame <= c_r.eof;
            out_valid_r        <= 1'b1;
            st_r               <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/gray_mirror_box_blur.sv @@
// gray_mirror_box_blur: top level; front, command queue and back.
// Depends on gmb_pkg, gmb_stream_if, gmb_front, gmb_queue, gmb_back.
//
// Gray, horizontally mirrored 9x9 box blur over a raster stream. Each input
// transaction writes one gray byte into a ten-row line store; from input row
// 5 on, each one also yields one blurred result of the row five rows above,
// in mirrored order. Width and height are to be written through cfg_* only while
// idle; the block itself does not enforce this. Cost per transaction is set by
// the single read port of the line store, which supplies one column sum in nine
// reads. No reads are made when no result is due; a result loads one column sum,
// the first result of each row five. No clearing pass is needed after reset.
module gray_mirror_box_blur #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  gmb_stream_if.sink                in_if,
  gmb_stream_if.source              out_if,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [gmb_pkg::CFG_W-1:0] cfg_data
);

  logic [gmb_pkg::CFG_W-1:0] width_r, height_r, w_eff, h_eff;
  logic                      cmd_valid, cmd_ready, q_valid, q_ready;
  gmb_pkg::cmd_t             cmd, q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= gmb_pkg::CFG_W'(640);
      height_r <= gmb_pkg::CFG_W'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        gmb_pkg::CFG_WIDTH:  width_r  <= cfg_data;
        gmb_pkg::CFG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) w_eff = gmb_pkg::CFG_W'(1);
    else if (32'(width_r) > MAX_WIDTH) w_eff = gmb_pkg::CFG_W'(MAX_WIDTH);
    else w_eff = width_r;
    if (height_r == '0) h_eff = gmb_pkg::CFG_W'(1);
    else if (32'(height_r) > MAX_HEIGHT) h_eff = gmb_pkg::CFG_W'(MAX_HEIGHT);
    else h_eff = height_r;
  end

  gmb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_data   (in_if.data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  gmb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (cmd_valid),
    .push_ready (cmd_ready),
    .push_data  (cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  gmb_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (out_if.data)
  );

endmodule

@@ test/tb_gray_mirror_box_blur.sv @@
// Testbench for gray_mirror_box_blur: directed frames, then random frames under
// several idle/stall mixes. Results are checked against an in-bench blur predictor,
// one-pixel frames against fixed values. Depends on gmb_pkg, gmb_stream_if, the DUT.
`timescale 1ns / 100ps

module tb_gray_mirror_box_blur;

  localparam int MAXW = 1024;
  localparam int MAXH = 1024;
  localparam int LIMIT = 500000;
  localparam int SETTLE = 100;

  typedef struct {
    logic       act;
    logic [7:0] b, g, r;
    bit         chk;
    logic [7:0] gexp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [gmb_pkg::CFG_W-1:0] cfg_data;

  gmb_stream_if #(.T(gmb_pkg::in_item_t))  in_ch();
  gmb_stream_if #(.T(gmb_pkg::out_item_t)) out_ch();

  gray_mirror_box_blur i_dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // blur predictor state
  logic [7:0] line_mem [gmb_pkg::SLOTS][MAXW];
  int unsigned px_col, px_row;
  logic [gmb_pkg::CFG_W-1:0] reg_width, reg_height;

  gmb_pkg::out_item_t blur_q[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int cycles = 0;
  int mode = 0;
  int hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout at %0t", $time);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int unsigned eff(logic [gmb_pkg::CFG_W-1:0] v, int unsigned mx);
    if (v == 0) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  function automatic logic [7:0] to_gray(gmb_pkg::in_item_t it);
    int unsigned s;
    s = 54 * it.red + 184 * it.green + 18 * it.blue;
    return (it.action == gmb_pkg::ACT_PIXEL) ? 8'(s >> 8) : 8'd0;
  endfunction

  task automatic blur_step(input gmb_pkg::in_item_t it, output bit has,
                           output gmb_pkg::out_item_t res);
    int unsigned w, h, c, r, orow, sum;
    int y, x;
    bit lc, lr;
    w = eff(reg_width, MAXW);
    h = eff(reg_height, MAXH);
    c = (px_col >= w) ? w - 1 : px_col;
    r = (px_row > h + gmb_pkg::DELAY - 1) ? h + gmb_pkg::DELAY - 1 : px_row;
    line_mem[r % gmb_pkg::SLOTS][w - 1 - c] = to_gray(it);
    lc = (c == w - 1);
    lr = (r == h + gmb_pkg::DELAY - 1);
    has = 0;
    res = '0;
    if (r >= gmb_pkg::DELAY && r - gmb_pkg::DELAY < h) begin
      orow = r - gmb_pkg::DELAY;
      sum = 0;
      for (y = int'(orow) - gmb_pkg::HALF; y <= int'(orow) + gmb_pkg::HALF; y++) begin
        if (y < 0 || y >= int'(h)) continue;
        for (x = int'(c) - gmb_pkg::HALF; x <= int'(c) + gmb_pkg::HALF; x++) begin
          if (x < 0 || x >= int'(w)) continue;
          sum += line_mem[y % gmb_pkg::SLOTS][x];
        end
      end
      res.gray_out = 8'(sum / (gmb_pkg::WINDOW * gmb_pkg::WINDOW));
      res.end_of_row = lc;
      res.end_of_frame = lc && (orow == h - 1);
      has = 1;
    end
    if (lc) begin
      px_col = 0;
      px_row = lr ? 0 : r + 1;
    end else begin
      px_col = c + 1;
      px_row = r;
    end
  endtask

  task automatic wait_idle();
    while (blur_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [gmb_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == gmb_pkg::CFG_WIDTH) reg_width = val;
    else reg_height = val;
  endtask

  task automatic send(input gmb_pkg::in_item_t it, input bit typed, input logic [7:0] gexp);
    bit has;
    gmb_pkg::out_item_t res;
    int pct;
    pct = (mode == 1) ? 76 : (mode == 3) ? 36 : 0;
    while (pct != 0 && $urandom_range(99) < pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    n_items++;
    blur_step(it, has, res);
    if (typed) begin
      res.gray_out = gexp;
      res.end_of_row = 1'b1;
      res.end_of_frame = 1'b1;
    end
    if (has) blur_q.push_back(res);
  endtask

  function automatic logic [7:0] rnd_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // image rows carry mostly pixels, drain rows mostly flush items
  function automatic gmb_pkg::in_item_t rnd_item();
    gmb_pkg::in_item_t it;
    it.blue = rnd_byte();
    it.green = rnd_byte();
    it.red = rnd_byte();
    if (px_row < eff(reg_height, MAXH)) it.action = ($urandom_range(15) == 0);
    else it.action = ($urandom_range(3) != 0);
    return it;
  endfunction

  task automatic send_n(input int n);
    int i;
    for (i = 0; i < n; i++) send(rnd_item(), 0, 8'd0);
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // sends from the current position up to the end of the frame
  task automatic run_frame(input bit sender_pause, input int hold);
    int unsigned h;
    bit paused;
    h = eff(reg_height, MAXH);
    paused = 0;
    if (hold > 0) begin
      @(posedge clk);
      hold_left = hold;
    end
    do begin
      if (sender_pause && !paused && px_row == h / 2 + gmb_pkg::DELAY && px_col == 0) begin
        paused = 1;
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (blur_q.size() != 0) @(posedge clk);
      end
      send(rnd_item(), 0, 8'd0);
    end while (px_col != 0 || px_row != 0);
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (mode == 2) begin
      out_ch.ready <= ($urandom_range(99) >= 76);
    end else if (mode == 3) begin
      out_ch.ready <= ($urandom_range(99) >= 36);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    gmb_pkg::out_item_t e, a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      n_results++;
      if (blur_q.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, a);
        errors++;
      end else begin
        e = blur_q.pop_front();
        if (a.gray_out !== e.gray_out || a.end_of_row !== e.end_of_row ||
            a.end_of_frame !== e.end_of_frame) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, e, a);
          errors++;
        end
      end
    end
  end

  dir_row_t dir_tab [24];

  initial begin
    gmb_pkg::in_item_t it;
    int k, fr, w, h;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = gmb_pkg::CFG_WIDTH;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    px_col = 0;
    px_row = 0;
    reg_width = 11'd640;
    reg_height = 11'd480;
    foreach (line_mem[i, j]) line_mem[i][j] = 8'd0;

    // one-pixel frames: white, black, pure red, flush pixel followed by drain pixels
    for (k = 0; k < 24; k++) begin
      dir_tab[k] = '{act: 1'b1, b: 8'h00, g: 8'h00, r: 8'h00, chk: 0, gexp: 8'd0};
      if (k % 6 == 5) dir_tab[k].chk = 1;
    end
    dir_tab[0] = '{1'b0, 8'hff, 8'hff, 8'hff, 0, 8'd0};
    dir_tab[5].gexp = 8'd3;
    dir_tab[6] = '{1'b0, 8'h00, 8'h00, 8'h00, 0, 8'd0};
    dir_tab[12] = '{1'b0, 8'h00, 8'h00, 8'hff, 0, 8'd0};
    for (k = 19; k < 24; k++) begin
      dir_tab[k].act = 1'b0;
      dir_tab[k].b = 8'hff;
      dir_tab[k].g = 8'hff;
      dir_tab[k].r = 8'hff;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(gmb_pkg::CFG_WIDTH, 11'd0);
    write_reg(gmb_pkg::CFG_HEIGHT, 11'd0);
    for (k = 0; k < 24; k++) begin
      it.action = dir_tab[k].act;
      it.blue = dir_tab[k].b;
      it.green = dir_tab[k].g;
      it.red = dir_tab[k].r;
      send(it, dir_tab[k].chk, dir_tab[k].gexp);
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait_idle();

    // smallest full-window frame
    mode = 0;
    write_reg(gmb_pkg::CFG_WIDTH, 11'd9);
    write_reg(gmb_pkg::CFG_HEIGHT, 11'd1);
    run_frame(0, 0);
    wait_idle();

    // width above the limit, then narrowed while the first row is open
    mode = 3;
    write_reg(gmb_pkg::CFG_WIDTH, 11'h7ff);
    write_reg(gmb_pkg::CFG_HEIGHT, 11'd1);
    send_n(30);
    wait_idle();
    write_reg(gmb_pkg::CFG_WIDTH, 11'd9);
    run_frame(0, 0);
    wait_idle();

    // height above the limit, then cut below the current row
    mode = 1;
    write_reg(gmb_pkg::CFG_WIDTH, 11'd1);
    write_reg(gmb_pkg::CFG_HEIGHT, 11'h7ff);
    send_n(10);
    wait_idle();
    write_reg(gmb_pkg::CFG_HEIGHT, 11'd3);
    run_frame(0, 0);
    wait_idle();

    for (fr = 0; fr < 4 || n_items < 950; fr++) begin
      mode = fr % 4;
      case ($urandom_range(9))
        0: w = $urandom_range(8, 1);
        1: w = $urandom_range(40, 25);
        default: w = $urandom_range(24, 9);
      endcase
      h = ($urandom_range(4) == 0) ? $urandom_range(12, 9) : $urandom_range(8, 1);
      if (fr == 2) begin
        w = 20;
        h = 6;
      end
      write_reg(gmb_pkg::CFG_WIDTH, gmb_pkg::CFG_W'(w));
      write_reg(gmb_pkg::CFG_HEIGHT, gmb_pkg::CFG_W'(h));
      run_frame(fr == 1, (fr == 2) ? 3000 : 0);
      wait_idle();
    end

    wait_idle();
    $display("covered %0d transactions in, %0d results out, %0d frames of random size",
             n_items, n_results, fr);
    $display("register extremes, mid-frame limits, drain/flush mixing, stalls, long hold-off");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
